### sv/fpa_pkg.sv
// Shared types and constants for the first-fit page allocator.
// Holds the controller/datapath command and status structs, status codes,
// page flag layout and configuration register indexes. No dependencies.
`default_nettype none

package fpa_pkg;

  localparam int DEF_MAX_PAGES  = 128;
  localparam int DEF_PAGE_SHIFT = 12;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = CFG_IDX_W'(1);

  localparam logic [ADDR_W-1:0]  RST_HEAP_BASE    = '0;
  localparam logic [COUNT_W-1:0] RST_PAGES_IN_USE = COUNT_W'(128);

  // page flag bits
  localparam int FLAG_TAKEN_BIT = 0;
  localparam int FLAG_LAST_BIT  = 1;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_ALLOC_FAIL   = 2'd1,
    ST_FREE_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_ALLOC_EV,
    OP_MARK,
    OP_FREE_CHK,
    OP_FREE_EV,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic alloc_bad;
    logic found;
    logic scan_end;
    logic mark_done;
    logic free_bad;
    logic free_stop;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/fpa_datapath.sv
// Datapath of the page allocator: config registers, page flag memory,
// scan/walk counters and the result register. Driven by fpa_ctrl.
// Depends on fpa_pkg.
`default_nettype none

module fpa_datapath
  import fpa_pkg::*;
#(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata,
  input  wire logic                 in_req_type,
  input  wire logic [COUNT_W-1:0]   in_page_count,
  input  wire logic [ADDR_W-1:0]    in_free_address,
  output logic [ADDR_W-1:0]         out_block_address,
  output logic [1:0]                out_status,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int N_W   = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
  localparam int EXT_W = ADDR_W + 2;

  logic [ADDR_W-1:0]  base_r;
  logic [COUNT_W-1:0] pages_r;
  logic [IDX_W-1:0]   idx_r;
  logic               req_type_r;
  logic [COUNT_W-1:0] count_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [N_W-1:0]     run_r;
  logic [N_W-1:0]     rem_r;
  logic [IDX_W-1:0]   start_r;
  logic               mark_last_r;
  logic [1:0]         rd_data_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic [ADDR_W-1:0]  out_block_address_r;
  status_t            out_status_r;

  logic [1:0] flag_mem [MAX_PAGES];

  logic [N_W-1:0]    n_pages;
  logic [N_W-1:0]    count_ext;
  logic [EXT_W-1:0]  heap_end;
  logic [ADDR_W-1:0] page_off;
  logic [ADDR_W-1:0] off_pg;
  logic              taken;
  logic              last;
  logic              mem_we;
  logic [1:0]        mem_wd;
  logic [ADDR_W-1:0] out_off;

  assign n_pages   = (N_W'(pages_r) > N_W'(MAX_PAGES)) ? N_W'(MAX_PAGES) : N_W'(pages_r);
  assign count_ext = N_W'(count_r);
  assign taken     = rd_data_r[FLAG_TAKEN_BIT];
  assign last      = rd_data_r[FLAG_LAST_BIT];
  assign heap_end  = EXT_W'(base_r) + (EXT_W'(n_pages) << PAGE_SHIFT);
  assign page_off  = addr_r - base_r;
  assign off_pg    = page_off >> PAGE_SHIFT;

  always_comb begin
    sts.clear_done = (idx_r == IDX_W'(MAX_PAGES - 1));
    sts.alloc_bad  = (count_r == '0) || (count_ext > n_pages);
    sts.found      = !taken && ((run_r + N_W'(1)) == count_ext);
    sts.scan_end   = ((N_W'(idx_r) + N_W'(1)) == n_pages);
    sts.mark_done  = (rem_r == N_W'(1));
    sts.free_bad   = (addr_r == '0) || (addr_r < base_r) || (EXT_W'(addr_r) >= heap_end);
    sts.free_stop  = !taken || last || (idx_r == IDX_W'(MAX_PAGES - 1));
  end

  always_comb begin
    mem_wd                 = '0;
    mem_wd[FLAG_TAKEN_BIT] = (cmd.op == OP_MARK);
    mem_wd[FLAG_LAST_BIT]  = (cmd.op == OP_MARK) && mark_last_r;
    mem_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_MARK) || ((cmd.op == OP_FREE_EV) && taken);
  end

  // flag memory: one write, one registered read, both at idx_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      flag_mem[idx_r] <= mem_wd;
    end
    rd_data_r <= flag_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_HEAP_BASE;
      pages_r <= RST_PAGES_IN_USE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:    base_r  <= cfg_wdata;
        CFG_PAGES_IN_USE: pages_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR:    idx_r <= idx_r + IDX_W'(1);
        OP_ACCEPT:   idx_r <= '0;
        OP_ALLOC_EV: if (!sts.found) idx_r <= idx_r + IDX_W'(1);
        OP_MARK:     idx_r <= idx_r - IDX_W'(1);
        OP_FREE_CHK: idx_r <= off_pg[IDX_W-1:0];
        OP_FREE_EV:  idx_r <= idx_r + IDX_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        req_type_r <= in_req_type;
        count_r    <= in_page_count;
        addr_r     <= in_free_address;
        run_r      <= '0;
      end
      OP_ALLOC_EV: begin
        run_r <= taken ? '0 : run_r + N_W'(1);
        if (sts.found) begin
          // mark from the run's end back to its start
          start_r     <= IDX_W'(N_W'(idx_r) + N_W'(1) - count_ext);
          rem_r       <= count_ext;
          mark_last_r <= 1'b1;
        end
      end
      OP_MARK: begin
        rem_r       <= rem_r - N_W'(1);
        mark_last_r <= 1'b0;
        res_addr_r  <= base_r + (ADDR_W'(start_r) << PAGE_SHIFT);
      end
      OP_LOAD_OUT: begin
        out_status_r        <= cmd.out_status;
        out_block_address_r <= ((cmd.out_status == ST_DONE) && !req_type_r) ? res_addr_r : '0;
      end
      default: ;
    endcase
  end

  assign out_block_address = out_block_address_r;
  assign out_status        = out_status_r;
  assign out_off           = out_block_address_r - base_r;

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MARK) |-> (N_W'(idx_r) < n_pages))
    else $error("mark write outside managed pages");

  a_free_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_FREE_CHK) && !sts.free_bad) |=> (N_W'(idx_r) < n_pages))
    else $error("free walk starts outside managed pages");

  a_alloc_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.op == OP_LOAD_OUT) && (cmd.out_status == ST_DONE) && !req_type_r)
      |=> (out_off[PAGE_SHIFT-1:0] == '0))
    else $error("allocated address not page aligned to base");

endmodule

`default_nettype wire

### sv/fpa_ctrl.sv
// Controller of the page allocator: sequences clear, scan, mark and free
// walk steps and owns the input ready and output valid handshake.
// Depends on fpa_pkg.
`default_nettype none

module fpa_ctrl
  import fpa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    in_req_type,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_CHK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_MARK,
    S_FREE_CHK,
    S_FREE_RD,
    S_FREE_EV,
    S_RESP
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_status_r, res_status_nxt;
  logic    out_valid_r, out_valid_nxt;
  dp_op_t  op;

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    op             = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_ACCEPT;
          state_nxt = in_req_type ? S_FREE_CHK : S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        if (sts.alloc_bad) begin
          res_status_nxt = ST_ALLOC_FAIL;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        op = OP_ALLOC_EV;
        priority if (sts.found) begin
          state_nxt = S_MARK;
        end else if (sts.scan_end) begin
          res_status_nxt = ST_ALLOC_FAIL;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_MARK: begin
        op = OP_MARK;
        if (sts.mark_done) begin
          res_status_nxt = ST_DONE;
          state_nxt      = S_RESP;
        end
      end
      S_FREE_CHK: begin
        op = OP_FREE_CHK;
        if (sts.free_bad) begin
          res_status_nxt = ST_FREE_IGNORED;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_FREE_RD: state_nxt = S_FREE_EV;
      S_FREE_EV: begin
        op = OP_FREE_EV;
        if (sts.free_stop) begin
          res_status_nxt = ST_DONE;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_FREE_RD;
        end
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          op        = OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    if (op == OP_LOAD_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      res_status_r <= ST_DONE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign cmd.op         = op;
  assign cmd.out_status = res_status_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result shown during clearing pass");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("output valid raised outside response step");

endmodule

`default_nettype wire

### sv/first_fit_page_allocator_core.sv
// Top level of the first-fit contiguous page allocator.
// Joins fpa_ctrl (sequencer) and fpa_datapath (flags memory, registers).
// Depends on fpa_pkg, fpa_ctrl, fpa_datapath.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_ready    in_req_type, in_page_count, in_free_address
//   out      source     out_valid/out_ready  out_block_address, out_status
//   cfg      sink       cfg_we               cfg_index, cfg_wdata
//
// Allocate: accept, count check, read and evaluate steps per scanned page, a mark
//   step per marked page, response. Free: accept, address check, read and evaluate
//   steps per walked page, response. The single flag memory port with its registered
//   read sets the pace. After reset a clearing pass frees every page, in_ready low.
// One request is in work at a time; a finished result waits in the output register
//   and the next request is taken while it waits.

`default_nettype none

module first_fit_page_allocator_core
  import fpa_pkg::*;
#(
  parameter int MAX_PAGES  = DEF_MAX_PAGES,
  parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [COUNT_W-1:0]   in_page_count,
  input  wire logic [ADDR_W-1:0]    in_free_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ADDR_W-1:0]         out_block_address,
  output logic [1:0]                out_status
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  fpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_page_count     (in_page_count),
    .in_free_address   (in_free_address),
    .out_block_address (out_block_address),
    .out_status        (out_status),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for first_fit_page_allocator_core: directed table, then random phases.
// Tracks the page flags itself and checks every beat on the result channel in order.
// Depends on fpa_pkg and the allocator RTL.

module tb_top;
  import fpa_pkg::*;

  localparam int NPAGES = DEF_MAX_PAGES;
  localparam int PSHIFT = DEF_PAGE_SHIFT;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = CFG_IDX_W'(3);

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_CYCLES     = 600;
  localparam int SETTLE_CYCLES   = 3 * NPAGES + 32;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int MAX_REPORTS     = 50;
  localparam int TIMEOUT_TIME    = 25_000_000;

  typedef struct packed {
    logic               req_type;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  free_address;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
  } page_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // value is the free address of a request or the data of a register write
  typedef struct packed {
    row_kind_t            kind;
    logic                 req_type;
    logic [COUNT_W-1:0]   page_count;
    logic [ADDR_W-1:0]    value;
    logic [CFG_IDX_W-1:0] cfg_sel;
    logic                 known;
    logic [ADDR_W-1:0]    exp_addr;
    status_t              exp_status;
  } stim_row_t;

  localparam int NUM_ROWS = 32;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_REQ, REQ_ALLOC, 8'd0,   32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_ALLOC_FAIL},
    '{ROW_REQ, REQ_ALLOC, 8'd129, 32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_ALLOC_FAIL},
    '{ROW_REQ, REQ_ALLOC, 8'd255, 32'hFFFF_FFFF, CFG_HEAP_BASE, 1'b1, 32'h0, ST_ALLOC_FAIL},
    '{ROW_REQ, REQ_ALLOC, 8'd1,   32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd128, 32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_ALLOC_FAIL},
    '{ROW_REQ, REQ_ALLOC, 8'd127, 32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h1000, ST_DONE},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_FREE_IGNORED},
    '{ROW_REQ, REQ_FREE,  8'd255, 32'h0008_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_FREE_IGNORED},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'hFFFF_FFFF, CFG_HEAP_BASE, 1'b1, 32'h0, ST_FREE_IGNORED},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0000_0FFF, CFG_HEAP_BASE, 1'b1, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0000_0800, CFG_HEAP_BASE, 1'b1, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0004_0000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd64,  32'h0000_0000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'h0000_0002, CFG_PAGES_IN_USE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd3,   32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_ALLOC_FAIL},
    // walk runs past the managed pages into the upper block
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0000_1000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd2,   32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_DONE},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'h0000_0000, CFG_PAGES_IN_USE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd1,   32'h0000_0000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_ALLOC_FAIL},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0000_0001, CFG_HEAP_BASE, 1'b1, 32'h0, ST_FREE_IGNORED},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'hFFFF_FFFF, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'h0000_00FF, CFG_PAGES_IN_USE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'hFFFF_FFFE, CFG_HEAP_BASE, 1'b1, 32'h0, ST_FREE_IGNORED},
    '{ROW_REQ, REQ_ALLOC, 8'd1,   32'h0000_0000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'hFFFF_FFFF, CFG_HEAP_BASE, 1'b1, 32'h0, ST_DONE},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'hFFFF_0000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd20,  32'h0000_0000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_ALLOC, 8'd16,  32'h0000_0000, CFG_HEAP_BASE, 1'b0, 32'h0, ST_DONE},
    // block address wrapped below the base, so its free is dropped
    '{ROW_REQ, REQ_FREE,  8'd0,   32'h0000_7000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_FREE_IGNORED},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'hFFFF_FFFF, CFG_IDX_SPARE_2, 1'b0, 32'h0, ST_DONE},
    '{ROW_CFG, REQ_ALLOC, 8'd0,   32'h1234_5678, CFG_IDX_SPARE_3, 1'b0, 32'h0, ST_DONE},
    '{ROW_REQ, REQ_FREE,  8'd0,   32'hFFFF_3000, CFG_HEAP_BASE, 1'b1, 32'h0, ST_DONE}
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [COUNT_W-1:0]   in_page_count = '0;
  logic [ADDR_W-1:0]    in_free_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_block_address;
  logic [1:0]           out_status;

  // page table as the block should hold it, plus its registers
  logic               pg_busy [NPAGES];
  logic               pg_tail [NPAGES];
  logic [ADDR_W-1:0]  heap_base = RST_HEAP_BASE;
  logic [COUNT_W-1:0] pages_set = RST_PAGES_IN_USE;

  page_result_t expected_results [$];
  int           live_pages [$];
  int           fail_count = 0;
  int           sent_count = 0;
  int           results_seen = 0;

  first_fit_page_allocator_core #(
    .MAX_PAGES (NPAGES),
    .PAGE_SHIFT(PSHIFT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_page_count    (in_page_count),
    .in_free_address  (in_free_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_block_address(out_block_address),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("simulation failed");
    $finish;
  end

  function automatic int managed_count();
    return (pages_set > NPAGES) ? NPAGES : int'(pages_set);
  endfunction

  function automatic page_result_t grant_pages(input logic [COUNT_W-1:0] cnt);
    page_result_t res;
    int n, start, k;
    bit fits;
    n = managed_count();
    res.block_address = '0;
    res.status = ST_ALLOC_FAIL;
    if (cnt == 0 || cnt > n) return res;
    for (start = 0; start + cnt <= n; start++) begin
      fits = 1'b1;
      for (k = 0; k < cnt; k++) begin
        if (pg_busy[start + k]) fits = 1'b0;
      end
      if (fits) begin
        for (k = 0; k < cnt; k++) pg_busy[start + k] = 1'b1;
        pg_tail[start + cnt - 1] = 1'b1;
        res.block_address = heap_base + (ADDR_W'(start) << PSHIFT);
        res.status = ST_DONE;
        return res;
      end
    end
    return res;
  endfunction

  function automatic page_result_t release_pages(input logic [ADDR_W-1:0] addr);
    page_result_t res;
    logic [ADDR_W:0] end_addr;
    int idx;
    bit was_last;
    res.block_address = '0;
    res.status = ST_FREE_IGNORED;
    end_addr = {1'b0, heap_base} + ((ADDR_W+1)'(managed_count()) << PSHIFT);
    if (addr == 0 || addr < heap_base || {1'b0, addr} >= end_addr) return res;
    idx = int'((addr - heap_base) >> PSHIFT);
    // stop after the last page of the block, at a free page or at the table end
    while (idx < NPAGES && pg_busy[idx]) begin
      was_last = pg_tail[idx];
      pg_busy[idx] = 1'b0;
      pg_tail[idx] = 1'b0;
      if (was_last) break;
      idx++;
    end
    res.status = ST_DONE;
    return res;
  endfunction

  function automatic int draw_idle(input int n);
    // every fourth stretch of 64 beats runs with no idling
    return ((n / 64) % 4 == 3) ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic page_req_t random_request();
    page_req_t req;
    int n, pick, slot;
    n = managed_count();
    req.req_type = REQ_ALLOC;
    req.page_count = COUNT_W'($urandom_range(0, 255));
    req.free_address = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) req.page_count = COUNT_W'($urandom_range(1, 8));
      else if (pick < 92) req.page_count = COUNT_W'($urandom_range(1, (n > 1) ? n : 1));
      else if (pick < 96) req.page_count = '0;
    end else begin
      req.req_type = REQ_FREE;
      pick = $urandom_range(0, 99);
      if (pick < 75 && live_pages.size() != 0) begin
        slot = $urandom_range(0, live_pages.size() - 1);
        req.free_address = heap_base + (ADDR_W'(live_pages[slot]) << PSHIFT);
        live_pages.delete(slot);
        // mostly the block head, sometimes a page further in
        if ($urandom_range(0, 3) == 0)
          req.free_address += ADDR_W'($urandom_range(0, 7)) << PSHIFT;
        else
          req.free_address += ADDR_W'($urandom_range(0, (1 << PSHIFT) - 1));
      end else if (pick < 82) begin
        req.free_address = '0;
      end else if (pick < 89) begin
        req.free_address = heap_base - ADDR_W'($urandom_range(1, 1 << PSHIFT));
      end else if (pick < 96 && n != 0) begin
        req.free_address = heap_base + ADDR_W'($urandom_range(0, n * (1 << PSHIFT) - 1));
      end
    end
    return req;
  endfunction

  task automatic offer(input page_req_t req, input logic known, input page_result_t known_res);
    page_result_t res;
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= req.req_type;
    in_page_count   <= req.page_count;
    in_free_address <= req.free_address;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.req_type == REQ_ALLOC) res = grant_pages(req.page_count);
    else res = release_pages(req.free_address);
    if (req.req_type == REQ_ALLOC && res.status == ST_DONE)
      live_pages.push_back(int'((res.block_address - heap_base) >> PSHIFT));
    if (known) res = known_res;
    expected_results.push_back(res);
    sent_count++;
    gap = draw_idle(sent_count);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] sel, input logic [ADDR_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == CFG_HEAP_BASE) heap_base = data;
    else if (sel == CFG_PAGES_IN_USE) pages_set = data[COUNT_W-1:0];
  endtask

  initial begin : result_check
    page_result_t want;
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_idle(results_seen);
      // long hold-off: the block fills up and drops in_ready
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("unexpected beat: block_address %h status %0d", out_block_address, out_status);
      end else begin
        want = expected_results.pop_front();
        if (out_block_address !== want.block_address) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("block_address mismatch: expected %h, actual %h",
                   want.block_address, out_block_address);
        end
        if (out_status !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t    row;
    page_req_t    req;
    page_result_t known_res;
    int r, phase, k, drain;
    for (k = 0; k < NPAGES; k++) begin
      pg_busy[k] = 1'b0;
      pg_tail[k] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_register(row.cfg_sel, row.value);
      end else begin
        req.req_type = row.req_type;
        req.page_count = row.page_count;
        req.free_address = row.value;
        known_res.block_address = row.exp_addr;
        known_res.status = row.exp_status;
        offer(req, row.known, known_res);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_register(CFG_HEAP_BASE, {20'($urandom_range(0, 32'hF_FFFF)), 12'h000});
          write_register(CFG_PAGES_IN_USE, ADDR_W'(128));
        end
        1: begin
          write_register(CFG_HEAP_BASE, 32'hFFFC_0000);
          write_register(CFG_PAGES_IN_USE, ADDR_W'(255));
        end
        2: begin
          write_register(CFG_HEAP_BASE, {20'($urandom_range(0, 32'hF_FFFF)), 12'h000});
          write_register(CFG_PAGES_IN_USE, ADDR_W'($urandom_range(1, 127)));
        end
        3: begin
          write_register(CFG_HEAP_BASE, $urandom());
          write_register(CFG_PAGES_IN_USE, ADDR_W'(200));
          write_register(CFG_IDX_SPARE_2, $urandom());
        end
        4: begin
          write_register(CFG_HEAP_BASE, 32'h0000_1000);
          write_register(CFG_PAGES_IN_USE, ADDR_W'(16));
        end
        default: begin
          write_register(CFG_HEAP_BASE, {20'($urandom_range(0, 32'hF_FFFF)), 12'h000});
          write_register(CFG_PAGES_IN_USE, ADDR_W'(128));
          write_register(CFG_IDX_SPARE_3, $urandom());
        end
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) offer(random_request(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    drain = 0;
    while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      fail_count++;
      $error("%0d expected results never arrived", expected_results.size());
    end

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
